### design/rde_pkg.sv
// Shared types and codes for the ring deque engine.
// Depends on nothing; rde_out_reg and ring_deque_engine refer to it by scoped names.
package rde_pkg;

    // Operation codes carried in the kind field of a request word.
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_LIST       = 3'd4;

    // Status codes returned in every response word.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Fixed widths of the response fields.
    localparam int ITEM_W = 32;
    localparam int OCC_W  = 5;

    // One response word as it travels to the output register.
    typedef struct packed {
        logic [1:0]        status;
        logic [ITEM_W-1:0] item;
        logic              last_of_run;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

### design/rde_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the contents are undefined until written.
module rde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/rde_out_reg.sv
// One-deep output register that holds a response word until it is taken.
// Depends on rde_pkg for the response word type.
module rde_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rde_pkg::result_t word_in,
    output logic             free,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rde_pkg::result_t word_out
);

    logic             valid_reg;
    logic             valid_next;
    rde_pkg::result_t word_reg;

    // The slot can take a word when it is empty or its word leaves now.
    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register; it changes only when a new word is loaded.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_in;
        end
    end

    assign rsp_valid = valid_reg;
    assign word_out  = word_reg;

endmodule

### design/ring_deque_engine.sv
// Double-ended queue of signed values kept in a ring memory.
// The request channel (req_valid, req_stall, kind, value) takes one word per
// operation: push front, push back, pop front, pop back or list all. The
// response channel (rsp_valid, rsp_stall, status, item, last_of_run,
// occupancy) returns the results from a one-deep output register.
// A push or a pop is done in the cycle it is accepted and its single response
// word is valid in the next cycle; a new request may follow at once, so these
// run at one word per cycle when the receiver keeps up. Kinds 5 to 7 are
// taken and dropped without a response.
// A list of N held entries reads the ring memory once per entry: each entry
// passes the registered read port of the ring memory and then the output
// register, and the words follow one per cycle while the receiver keeps up.
// Listing an empty queue gives one word.
// While a list runs, req_stall stays high.
// When the receiver stalls, the output register holds its word and the block
// raises req_stall (or pauses the list) until the word is taken.
// Reset empties the queue at once; the ring memory needs no clearing pass,
// since only entries that were written are ever read.
// Depends on rde_pkg, rde_ram and rde_out_reg.
module ring_deque_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic signed [31:0] item,
    output logic               last_of_run,
    output logic [4:0]         occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] walk_reg;
    logic [IDX_W-1:0] walk_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;

    logic             accept;
    logic             out_free;
    logic             out_load;
    rde_pkg::result_t out_word;
    rde_pkg::result_t rsp_word;

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] tail_inc;
    logic [IDX_W-1:0] tail_dec;
    logic [IDX_W-1:0] walk_inc;
    logic             is_full;
    logic             is_empty;

    // Ring index arithmetic, wrapping at DEPTH.
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign walk_inc = (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;

    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    // Requests are taken only when idle and the output slot has room.
    assign req_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = req_valid && !req_stall;

    // The pushed value is sign-extended or cut to the stored width.
    assign ram_wr_data = DATA_WIDTH'(value);

    // Operation control: pointer updates, ring access and response word.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        left_next   = left_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;
        out_load    = 1'b0;
        out_word.status      = rde_pkg::STATUS_OK;
        out_word.item        = '0;
        out_word.last_of_run = 1'b1;
        out_word.occupancy   = rde_pkg::OCC_W'(count_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        rde_pkg::KIND_PUSH_FRONT, rde_pkg::KIND_PUSH_BACK:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                out_word.status = rde_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (kind == rde_pkg::KIND_PUSH_FRONT)
                                begin
                                    head_next   = head_dec;
                                    ram_wr_addr = head_dec;
                                end
                                else
                                begin
                                    tail_next   = tail_inc;
                                    ram_wr_addr = tail_reg;
                                end
                                out_word.occupancy = rde_pkg::OCC_W'(count_next);
                            end
                        end
                        rde_pkg::KIND_POP_FRONT, rde_pkg::KIND_POP_BACK:
                        begin
                            out_load = 1'b1;
                            if (is_empty)
                            begin
                                out_word.status = rde_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                if (kind == rde_pkg::KIND_POP_FRONT)
                                begin
                                    head_next = head_inc;
                                end
                                else
                                begin
                                    tail_next = tail_dec;
                                end
                                out_word.occupancy = rde_pkg::OCC_W'(count_next);
                            end
                        end
                        rde_pkg::KIND_LIST:
                        begin
                            if (is_empty)
                            begin
                                out_load        = 1'b1;
                                out_word.status = rde_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // Fetch the front entry; the walk starts next cycle.
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg;
                                walk_next   = head_reg;
                                left_next   = count_reg;
                                state_next  = ST_LIST;
                            end
                        end
                        default:
                        begin
                            // Unused kinds are dropped without a response.
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                // Emit the fetched entry and fetch the next one in the same cycle.
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_word.item        = rde_pkg::ITEM_W'(ram_rd_data);
                    out_word.last_of_run = (left_reg == CNT_W'(1));
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = walk_inc;
                        walk_next   = walk_inc;
                        left_next   = left_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            walk_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            left_reg  <= left_next;
        end
    end

    // Ring storage.
    rde_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register toward the receiver.
    rde_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .word_in   (out_word),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .word_out  (rsp_word)
    );

    assign status      = rsp_word.status;
    assign item        = rsp_word.item;
    assign last_of_run = rsp_word.last_of_run;
    assign occupancy   = rsp_word.occupancy;

    // The count never passes the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
    else $error("entry count exceeds ring depth");

    // Head, tail and count stay consistent around the ring.
    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ((32'(head_reg) + 32'(count_reg)) % DEPTH) == 32'(tail_reg))
    else $error("head, tail and count disagree");

    // A list walk never changes the contents; this checks that the entry count stays.
    a_list_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |=> (count_reg == $past(count_reg)))
    else $error("entry count changed during a list");

    // A walk in progress always has an entry left to emit.
    a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (left_reg != '0))
    else $error("list walk with nothing left");

    // Every list word but the last is followed by more of the same walk.
    a_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST && out_load && !out_word.last_of_run)
        |=> (state_reg == ST_LIST))
    else $error("list walk ended before its last word");

endmodule
